// ----- hdl/twm_pkg.sv -----
// twm_pkg: shared types, register codes and reset values of the trigger window merger
// used by twm_front, twm_back and trigger_window_merger; depends on nothing
package twm_pkg;

  // default configuration of the block
  localparam int TableDepthDef = 16;
  localparam int TypeCountDef  = 16;
  localparam int TimingTypeDef = 1;
  localparam int MaxResults    = 16;

  // register indexes of the configuration port
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_MERGE_ENABLE       = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_PASSTHROUGH_ENABLE = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TIMEOUT       = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_LIMIT       = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_IGNORE_TYPE_MASK   = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAPPED_TYPE_MASK   = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_BEFORE      = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_AFTER       = 4'd7;

  // result kinds
  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_DROPPED  = 1'b1;

  // operation codes
  localparam logic OP_CANDIDATE = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  // reset values
  localparam logic [19:0] HoldTimeoutRst = 20'd1000;
  localparam logic [62:0] WindowLimitRst = 63'd100000;

  typedef struct packed {
    logic        operation;
    logic [3:0]  cand_type;
    logic [63:0] cand_time;
    logic [63:0] cand_start;
    logic [63:0] cand_end;
    logic [15:0] cand_detector;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] decision_time;
    logic [15:0] decision_type;
    logic [63:0] window_start;
    logic [63:0] win_end;
    logic [7:0]  contributor_count;
    logic [15:0] type_bits;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic        merge_enable;
    logic        passthrough_enable;
    logic [19:0] hold_timeout;
    logic [62:0] window_limit;
    logic [15:0] ignore_type_mask;
    logic [15:0] mapped_type_mask;
    logic [63:0] offset_before;
    logic [63:0] offset_after;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic        is_tick;
    logic [3:0]  ctype;
    logic [63:0] ctime;
    logic [63:0] cstart;
    logic [63:0] cend;
    logic [15:0] cdet;
  } cmd_t;

  // one pending window in the table
  typedef struct packed {
    logic [63:0] wstart;
    logic [63:0] wend;
    logic [63:0] expiry;
    logic [63:0] first_time;
    logic [3:0]  first_type;
    logic [15:0] first_det;
    logic [15:0] type_bits;
    logic [7:0]  count;
  } entry_t;

endpackage

// ----- hdl/twm_front.sv -----
// twm_front: accepts input words, drops ignored types, maps windows, queues commands
// depends on twm_pkg
module twm_front
  import twm_pkg::*;
#(
  parameter int TYPE_COUNT = TypeCountDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word_i,
  output cmd_t     cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i
);

  logic       ignored, mapped, wr;
  cmd_t       cmd_w;
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  // classify the incoming word
  always_comb begin
    ignored = (in_word_i.operation == OP_CANDIDATE) &&
              (32'(in_word_i.cand_type) < TYPE_COUNT) &&
              cfg_i.ignore_type_mask[in_word_i.cand_type];
    mapped  = (32'(in_word_i.cand_type) < TYPE_COUNT) &&
              cfg_i.mapped_type_mask[in_word_i.cand_type];
    cmd_w.is_tick = (in_word_i.operation == OP_TICK);
    cmd_w.ctype   = in_word_i.cand_type;
    cmd_w.ctime   = in_word_i.cand_time;
    cmd_w.cdet    = in_word_i.cand_detector;
    cmd_w.cstart  = mapped ? in_word_i.cand_time - cfg_i.offset_before : in_word_i.cand_start;
    cmd_w.cend    = mapped ? in_word_i.cand_time + cfg_i.offset_after : in_word_i.cand_end;
  end

  assign full        = (cnt_q == 2'd2);
  assign wr          = push && !full && !ignored;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // two-entry command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr) wr_ptr_q <= !wr_ptr_q;
      if (cmd_pop_i && cmd_valid_o) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(cmd_pop_i && cmd_valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) fifo_q[wr_ptr_q] <= cmd_w;
  end

endmodule

// ----- hdl/twm_back.sv -----
// twm_back: window table, scan sequencer, tick counter and result register
// depends on twm_pkg
module twm_back
  import twm_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int TIMING_TYPE = TimingTypeDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW   = $clog2(MaxResults + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_PLACE = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d, free_idx_q, free_idx_d;
  logic                   free_found_q, free_found_d;
  logic [NW-1:0]          n_q, n_d;
  logic [63:0]            tick_q, tick_d;
  cmd_t                   cmd_q, cmd_d;
  out_word_t              hold_q, hold_d, out_q, out_push_word;
  logic                   hold_valid_q, hold_valid_d, out_valid_q, out_push, out_take;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_q, merged, new_ent, mem_wdata;
  logic                   mem_we, mem_re;
  logic [IdxW-1:0]        mem_waddr;
  logic                   cur_valid, hit, ready_ent, last_idx;
  logic [64:0]            exp_sum;
  logic [63:0]            expiry_now, wlen;
  logic [15:0]            tbit, dtype;
  out_word_t              dec_word, drop_word;

  // per-entry arithmetic on the word just read
  always_comb begin
    exp_sum    = {1'b0, tick_q} + {45'd0, cfg_i.hold_timeout};
    expiry_now = exp_sum[64] ? '1 : exp_sum[63:0];
    tbit       = 16'd1 << cmd_q.ctype;
    cur_valid  = valid_q[idx_q];
    last_idx   = (idx_q == IdxW'(TABLE_DEPTH - 1));
    hit = cfg_i.merge_enable && cur_valid &&
          !((cmd_q.cend < rd_q.wstart) || (cmd_q.cstart > rd_q.wend));
    wlen      = rd_q.wend - rd_q.wstart;
    ready_ent = cur_valid && (n_q < NW'(MaxResults)) &&
                ((tick_q >= rd_q.expiry) ||
                 (!wlen[63] && (wlen[62:0] >= cfg_i.window_limit)));

    merged            = rd_q;
    merged.wstart     = (cmd_q.cstart < rd_q.wstart) ? cmd_q.cstart : rd_q.wstart;
    merged.wend       = (cmd_q.cend > rd_q.wend) ? cmd_q.cend : rd_q.wend;
    merged.expiry     = expiry_now;
    merged.type_bits  = rd_q.type_bits | tbit;
    merged.count      = (rd_q.count != 8'hff) ? rd_q.count + 8'd1 : rd_q.count;
    if (cmd_q.ctime < rd_q.first_time) begin
      merged.first_time = cmd_q.ctime;
      merged.first_type = cmd_q.ctype;
      merged.first_det  = cmd_q.cdet;
    end

    new_ent.wstart     = cmd_q.cstart;
    new_ent.wend       = cmd_q.cend;
    new_ent.expiry     = expiry_now;
    new_ent.first_time = cmd_q.ctime;
    new_ent.first_type = cmd_q.ctype;
    new_ent.first_det  = cmd_q.cdet;
    new_ent.type_bits  = tbit;
    new_ent.count      = 8'd1;

    if (!cfg_i.passthrough_enable) dtype = 16'd1;
    else if (rd_q.first_type == 4'(TIMING_TYPE)) dtype = {8'd0, rd_q.first_det[7:0]};
    else dtype = {4'd0, rd_q.first_type, 8'd0};

    dec_word = '{kind: KIND_DECISION, decision_time: rd_q.first_time, decision_type: dtype,
                 window_start: rd_q.wstart, win_end: rd_q.wend,
                 contributor_count: rd_q.count, type_bits: rd_q.type_bits, last: 1'b0};
    drop_word = '{kind: KIND_DROPPED, decision_time: cmd_q.ctime, decision_type: 16'd0,
                  window_start: cmd_q.cstart, win_end: cmd_q.cend,
                  contributor_count: 8'd1, type_bits: tbit, last: 1'b0};
  end

  assign out_take = !out_valid_q || pop;

  // scan sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    free_idx_d    = free_idx_q;
    free_found_d  = free_found_q;
    n_d           = n_q;
    tick_d        = tick_q;
    cmd_d         = cmd_q;
    hold_d        = hold_q;
    hold_valid_d  = hold_valid_q;
    valid_d       = valid_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = idx_q;
    mem_wdata     = merged;
    cmd_pop_o     = 1'b0;
    out_push      = 1'b0;
    out_push_word = hold_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          cmd_d        = cmd_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          n_d          = '0;
          if (cmd_i.is_tick) tick_d = tick_q + 64'd1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!cmd_q.is_tick) begin
          if (hit) begin
            mem_we  = 1'b1;
            state_d = S_IDLE;
          end else begin
            if (!cur_valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = idx_q;
            end
            if (last_idx) state_d = S_PLACE;
            else begin
              idx_d   = idx_q + IdxW'(1);
              state_d = S_READ;
            end
          end
        end else if (!(ready_ent && hold_valid_q && !out_take)) begin
          if (ready_ent) begin
            if (hold_valid_q) out_push = 1'b1;
            hold_d         = dec_word;
            hold_valid_d   = 1'b1;
            valid_d[idx_q] = 1'b0;
            n_d            = n_q + NW'(1);
          end
          if (last_idx) state_d = S_FLUSH;
          else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_READ;
          end
        end
      end
      S_PLACE: begin
        if (free_found_q) begin
          mem_we              = 1'b1;
          mem_waddr           = free_idx_q;
          mem_wdata           = new_ent;
          valid_d[free_idx_q] = 1'b1;
          state_d             = S_IDLE;
        end else begin
          hold_d       = drop_word;
          hold_valid_d = 1'b1;
          state_d      = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!hold_valid_q) state_d = S_IDLE;
        else if (out_take) begin
          out_push           = 1'b1;
          out_push_word.last = 1'b1;
          hold_valid_d       = 1'b0;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      free_idx_q   <= '0;
      free_found_q <= 1'b0;
      n_q          <= '0;
      tick_q       <= '0;
      hold_valid_q <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_idx_q   <= free_idx_d;
      free_found_q <= free_found_d;
      n_q          <= n_d;
      tick_q       <= tick_d;
      hold_valid_q <= hold_valid_d;
      valid_q      <= valid_d;
      if (out_push) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    hold_q <= hold_d;
    if (out_push) out_q <= out_push_word;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[idx_q];
  end

  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

  // no word is parked once the sequencer is back at rest
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_valid_q) else $error("word left in hold register");

  // a new window never lands on a live entry
  a_place_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_PLACE) && free_found_q) |-> !valid_q[free_idx_q])
    else $error("new window overwrites a valid entry");

  // a tick never emits more than the per-tick budget
  a_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MaxResults)) else $error("too many results for one tick");

  // a result push always finds room in the output register
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> out_take) else $error("output register overrun");

endmodule

// ----- hdl/trigger_window_merger.sv -----
// trigger_window_merger: top level with configuration registers, front and back
// depends on twm_pkg, twm_front and twm_back
//
//   channel   handshake              payload
//   input     push / full            in_word_i  (in_word_t)
//   result    empty / pop            out_word_o (out_word_t)
//   config    cfg_we_i, cfg_index_i  cfg_data_i (64 bits)
//
// a stored candidate or a tick scans every table entry in the back: the scan reads
// one entry per S_READ and S_EVAL pass through the single registered memory read port
// a merge ends at the matching entry, a table-full result adds S_FLUSH, and a tick
// stalls while a finished result waits on pop
// the two-entry command queue keeps taking words while the back scans, until it is full
// reset clears valid bits and counters at once; there is no clearing pass
module trigger_window_merger
  import twm_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int TYPE_COUNT  = TypeCountDef,
  parameter int TIMING_TYPE = TimingTypeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_word_t           in_word_i,
  output logic               empty,
  input  logic               pop,
  output out_word_t          out_word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.merge_enable       <= 1'b1;
      cfg_q.passthrough_enable <= 1'b0;
      cfg_q.hold_timeout       <= HoldTimeoutRst;
      cfg_q.window_limit       <= WindowLimitRst;
      cfg_q.ignore_type_mask   <= '0;
      cfg_q.mapped_type_mask   <= '0;
      cfg_q.offset_before      <= '0;
      cfg_q.offset_after       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MERGE_ENABLE:       cfg_q.merge_enable       <= cfg_data_i[0];
        CFG_PASSTHROUGH_ENABLE: cfg_q.passthrough_enable <= cfg_data_i[0];
        CFG_HOLD_TIMEOUT:       cfg_q.hold_timeout       <= cfg_data_i[19:0];
        CFG_WINDOW_LIMIT:       cfg_q.window_limit       <= cfg_data_i[62:0];
        CFG_IGNORE_TYPE_MASK:   cfg_q.ignore_type_mask   <= cfg_data_i[15:0];
        CFG_MAPPED_TYPE_MASK:   cfg_q.mapped_type_mask   <= cfg_data_i[15:0];
        CFG_OFFSET_BEFORE:      cfg_q.offset_before      <= cfg_data_i;
        CFG_OFFSET_AFTER:       cfg_q.offset_after       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  twm_front #(
    .TYPE_COUNT(TYPE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  twm_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TIMING_TYPE(TIMING_TYPE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

endmodule

// ----- sim/twm_checker.sv -----
// twm_checker: watches the input, result and config channels of the trigger window merger
// keeps its own copy of the window table, predicts every result word and compares; uses twm_pkg
module twm_checker
  import twm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  in_word_t           in_word_i,
  input  logic               empty,
  input  logic               pop,
  input  out_word_t          out_word_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 word_count_o,
  output int                 result_count_o,
  output int                 drop_count_o
);

  localparam int Depth  = TableDepthDef;
  localparam int Timing = TimingTypeDef;

  // mirrored configuration
  cfg_t cfg_q;

  // mirrored window table
  logic        slot_used  [Depth];
  logic [63:0] slot_start [Depth];
  logic [63:0] slot_end   [Depth];
  logic [63:0] slot_expiry[Depth];
  logic [63:0] slot_time  [Depth];
  logic [3:0]  slot_type  [Depth];
  logic [15:0] slot_det   [Depth];
  logic [15:0] slot_bits  [Depth];
  logic [7:0]  slot_count [Depth];
  logic [63:0] ms_ticks;

  out_word_t expected_words[$];

  assign pending_o = expected_words.size();

  function automatic logic [63:0] hold_expiry();
    logic [64:0] sum;
    sum = {1'b0, ms_ticks} + {45'b0, cfg_q.hold_timeout};
    return sum[64] ? '1 : sum[63:0];
  endfunction

  function automatic logic window_too_long(int i);
    logic [63:0] len;
    len = slot_end[i] - slot_start[i];
    return !len[63] && (len >= {1'b0, cfg_q.window_limit});
  endfunction

  // candidate: ignore, merge, store or report a full table
  task automatic take_candidate(in_word_t w);
    logic [63:0] cs, ce;
    logic [15:0] tbit;
    out_word_t r;
    cs = w.cand_start;
    ce = w.cand_end;
    tbit = 16'h1 << w.cand_type;
    if (cfg_q.ignore_type_mask[w.cand_type]) return;
    if (cfg_q.mapped_type_mask[w.cand_type]) begin
      cs = w.cand_time - cfg_q.offset_before;
      ce = w.cand_time + cfg_q.offset_after;
    end
    if (cfg_q.merge_enable) begin
      for (int i = 0; i < Depth; i++) begin
        if (!slot_used[i] || ce < slot_start[i] || cs > slot_end[i]) continue;
        if (cs < slot_start[i]) slot_start[i] = cs;
        if (ce > slot_end[i]) slot_end[i] = ce;
        if (w.cand_time < slot_time[i]) begin
          slot_time[i] = w.cand_time;
          slot_type[i] = w.cand_type;
          slot_det[i]  = w.cand_detector;
        end
        slot_bits[i] |= tbit;
        if (slot_count[i] != 8'hff) slot_count[i]++;
        slot_expiry[i] = hold_expiry();
        return;
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (slot_used[i]) continue;
      slot_used[i]   = 1'b1;
      slot_start[i]  = cs;
      slot_end[i]    = ce;
      slot_time[i]   = w.cand_time;
      slot_type[i]   = w.cand_type;
      slot_det[i]    = w.cand_detector;
      slot_bits[i]   = tbit;
      slot_count[i]  = 8'd1;
      slot_expiry[i] = hold_expiry();
      return;
    end
    r = '{kind: KIND_DROPPED, decision_time: w.cand_time, decision_type: 16'h0,
          window_start: cs, win_end: ce, contributor_count: 8'd1,
          type_bits: tbit, last: 1'b1};
    expected_words.insert(expected_words.size(), r);
  endtask

  // tick: emit ready windows in table order, at most MaxResults per tick
  task automatic take_tick();
    out_word_t batch[$];
    out_word_t r;
    logic [15:0] dtype;
    ms_ticks++;
    for (int i = 0; i < Depth && batch.size() < MaxResults; i++) begin
      if (!slot_used[i]) continue;
      if (!(ms_ticks >= slot_expiry[i] || window_too_long(i))) continue;
      if (!cfg_q.passthrough_enable) dtype = 16'd1;
      else if (slot_type[i] == Timing) dtype = {8'h0, slot_det[i][7:0]};
      else dtype = {4'h0, slot_type[i], 8'h0};
      r = '{kind: KIND_DECISION, decision_time: slot_time[i], decision_type: dtype,
            window_start: slot_start[i], win_end: slot_end[i],
            contributor_count: slot_count[i], type_bits: slot_bits[i], last: 1'b0};
      batch.insert(batch.size(), r);
      slot_used[i] = 1'b0;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_words.insert(expected_words.size(), batch[k]);
  endtask

  task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      fail_count_o++;
    end
  endtask

  task automatic check_word(out_word_t a);
    out_word_t e;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: %p", a);
      fail_count_o++;
      return;
    end
    e = expected_words.pop_front();
    cmp("kind", 64'(e.kind), 64'(a.kind));
    cmp("decision_time", e.decision_time, a.decision_time);
    cmp("decision_type", 64'(e.decision_type), 64'(a.decision_type));
    cmp("window_start", e.window_start, a.window_start);
    cmp("window_end", e.win_end, a.win_end);
    cmp("contributor_count", 64'(e.contributor_count), 64'(a.contributor_count));
    cmp("type_bits", 64'(e.type_bits), 64'(a.type_bits));
    cmp("last", 64'(e.last), 64'(a.last));
    if (a.kind == KIND_DROPPED) drop_count_o++;
  endtask

  // channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q = '{merge_enable: 1'b1, passthrough_enable: 1'b0, hold_timeout: HoldTimeoutRst,
                window_limit: WindowLimitRst, ignore_type_mask: '0, mapped_type_mask: '0,
                offset_before: '0, offset_after: '0};
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      ms_ticks = '0;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MERGE_ENABLE:       cfg_q.merge_enable       = cfg_data_i[0];
          CFG_PASSTHROUGH_ENABLE: cfg_q.passthrough_enable = cfg_data_i[0];
          CFG_HOLD_TIMEOUT:       cfg_q.hold_timeout       = cfg_data_i[19:0];
          CFG_WINDOW_LIMIT:       cfg_q.window_limit       = cfg_data_i[62:0];
          CFG_IGNORE_TYPE_MASK:   cfg_q.ignore_type_mask   = cfg_data_i[15:0];
          CFG_MAPPED_TYPE_MASK:   cfg_q.mapped_type_mask   = cfg_data_i[15:0];
          CFG_OFFSET_BEFORE:      cfg_q.offset_before      = cfg_data_i;
          CFG_OFFSET_AFTER:       cfg_q.offset_after       = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        word_count_o++;
        if (in_word_i.operation == OP_CANDIDATE) take_candidate(in_word_i);
        else take_tick();
      end
      if (pop && !empty) begin
        result_count_o++;
        check_word(out_word_i);
      end
    end
  end

  initial begin
    fail_count_o   = 0;
    word_count_o   = 0;
    result_count_o = 0;
    drop_count_o   = 0;
  end

endmodule

// ----- sim/trigger_window_merger_tb.sv -----
// trigger_window_merger_tb: drives candidates, ticks and config writes into the merger
// depends on twm_pkg, trigger_window_merger and twm_checker, which predicts and compares
module trigger_window_merger_tb;
  import twm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 4'd9;
  localparam int SettleCycles = 200;
  localparam int CycleLimit   = 1000000;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  in_word_t           in_word;
  logic               empty;
  logic               pop;
  out_word_t          out_word;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;

  int fail_count, pending, word_count, result_count, drop_count;
  int cycles;
  bit quiet;

  trigger_window_merger DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .in_word_i(in_word),
    .empty(empty), .pop(pop), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  twm_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .in_word_i(in_word),
    .empty(empty), .pop(pop), .out_word_i(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .word_count_o(word_count),
    .result_count_o(result_count), .drop_count_o(drop_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic in_word_t cand(logic [3:0] t, logic [63:0] tm, logic [63:0] s,
                                    logic [63:0] e, logic [15:0] det);
    return '{operation: OP_CANDIDATE, cand_type: t, cand_time: tm, cand_start: s,
             cand_end: e, cand_detector: det};
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = '{default: '0};
    w.operation = OP_TICK;
    w.cand_time = {$urandom, $urandom};
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly clustered windows so merges happen, some wide random words
  function automatic in_word_t rand_cand();
    logic [63:0] tm;
    if ($urandom_range(0, 9) == 0)
      return cand(4'($urandom), rand64(), rand64(), rand64(), 16'($urandom));
    tm = 64'($urandom_range(0, 3000));
    return cand(4'($urandom), tm, tm - 64'($urandom_range(0, 60)),
                tm + 64'($urandom_range(0, 60)), 16'($urandom));
  endfunction

  // one word through push/full
  task automatic send_word(in_word_t w);
    int gap;
    bit taken;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // drain every expected word, then let in-flight scans finish
  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_MERGE_ENABLE, {63'b0, c.merge_enable});
    write_reg(CFG_PASSTHROUGH_ENABLE, {63'b0, c.passthrough_enable});
    write_reg(CFG_HOLD_TIMEOUT, {44'b0, c.hold_timeout});
    write_reg(CFG_WINDOW_LIMIT, {1'b0, c.window_limit});
    write_reg(CFG_IGNORE_TYPE_MASK, {48'b0, c.ignore_type_mask});
    write_reg(CFG_MAPPED_TYPE_MASK, {48'b0, c.mapped_type_mask});
    write_reg(CFG_OFFSET_BEFORE, c.offset_before);
    write_reg(CFG_OFFSET_AFTER, c.offset_after);
    // unused index must leave every register alone
    write_reg(CfgIdxUnused, rand64());
    cfg_we <= 1'b0;
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    pop = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(negedge clk_i); while (empty);
      @(posedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    cfg_t c;
    push      = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    rst_ni    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: merge, earliest-time replacement, extremes, too-long and negative windows
    send_word(cand(4'd0, 64'd100, 64'd90, 64'd110, 16'hffff));
    send_word(cand(4'd15, 64'd50, 64'd105, 64'd120, 16'h0001));
    send_word(cand(4'd1, '1, '1, '1, 16'h0000));
    send_word(cand(4'd3, 64'd7, 64'd5, 64'h4000_0000_0000_0000, 16'h1234));
    send_word(cand(4'd4, 64'd0, 64'd1000, 64'd10, 16'h5a5a));
    send_word(cand(4'd0, 64'd0, 64'd0, 64'd0, 16'h0000));
    send_word(tick_word());
    settle();

    // no merging, passthrough, zero hold, ignored and mapped types with wrap, full table
    c = '{merge_enable: 1'b0, passthrough_enable: 1'b1, hold_timeout: 20'd0,
          window_limit: '1, ignore_type_mask: 16'h0004, mapped_type_mask: 16'h0020,
          offset_before: 64'd10, offset_after: 64'hffff_ffff_ffff_fffb};
    apply_config(c);
    for (int i = 0; i < 17; i++)
      send_word(cand((i == 2) ? 4'd3 : 4'(i), 64'd3 + 64'(i), 64'(i * 100),
                     64'(i * 100 + 5), 16'hab00 + 16'(i)));
    send_word(cand(4'd2, 64'd1, 64'd1, 64'd2, 16'h0));
    send_word(tick_word());
    settle();

    // random phases, extremes among the settings
    for (int p = 0; p < 8; p++) begin
      c.merge_enable       = 1'($urandom);
      c.passthrough_enable = 1'($urandom);
      case ($urandom_range(0, 3))
        0: c.hold_timeout = 20'd0;
        1: c.hold_timeout = '1;
        default: c.hold_timeout = 20'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 3))
        0: c.window_limit = '0;
        1: c.window_limit = '1;
        2: c.window_limit = 63'd100000;
        default: c.window_limit = 63'($urandom_range(40, 200));
      endcase
      c.ignore_type_mask = (p == 3) ? 16'hfffe : 16'($urandom & $urandom);
      c.mapped_type_mask = (p == 2) ? 16'hffff : 16'($urandom);
      c.offset_before    = (p == 2) ? '1 : ((p == 5) ? rand64() : 64'($urandom_range(0, 40)));
      c.offset_after     = (p == 2) ? '1 : ((p == 5) ? rand64() : 64'($urandom_range(0, 40)));
      if (p == 0) begin
        c.merge_enable = 1'b1;
        c.passthrough_enable = 1'b1;
      end
      apply_config(c);
      quiet = (p % 3 == 1);
      for (int k = 0; k < 8; k++)
        send_word(($urandom_range(0, 9) < 3) ? tick_word() : rand_cand());
      send_word(tick_word());
      settle();
    end

    // one window taking many candidates so the count saturates
    c = '{merge_enable: 1'b1, passthrough_enable: 1'b1, hold_timeout: '1,
          window_limit: '0, ignore_type_mask: '0, mapped_type_mask: '0,
          offset_before: '0, offset_after: '0};
    apply_config(c);
    quiet = 1'b1;
    for (int k = 0; k < 257; k++)
      send_word(cand(4'($urandom), 64'($urandom_range(10, 20)), 64'd10, 64'd20,
                     16'($urandom)));
    quiet = 1'b0;
    send_word(tick_word());
    settle();

    $display("covered %0d input words and %0d result words, %0d of them table-full drops",
             word_count, result_count, drop_count);
    $display("over reset settings, directed corner settings and 8 random setting phases");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
